// ===== rtl/core/oplp_pkg.sv =====
// shared types and constants of the one-pole low-pass filter core
package oplp_pkg;

    // fixed field widths of the streaming and configuration ports
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 1;
    localparam int ERR_W     = 3;
    localparam int OUT_W     = 40;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_FREQ = 1'd1;

    // error codes reported with each result, first failing check wins
    localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
    localparam logic [ERR_W-1:0] ERR_RATE_ZERO = 3'd1;
    localparam logic [ERR_W-1:0] ERR_RATE_HIGH = 3'd2;
    localparam logic [ERR_W-1:0] ERR_CUT_HIGH  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_NYQUIST   = 3'd4;

    // 2*pi in 3.32 fixed point, truncated
    localparam longint unsigned TAU_Q32 = 64'd26986075409;

    // quotient bits produced by the gain divider
    localparam int DIV_STEPS = 33;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // latch sample, error code and cutoff product
        logic den_add;   // finish denominator, seed divider remainder
        logic div_step;  // one restoring division step
        logic mul_a;     // first term: sample times alpha
        logic mul_b;     // second term: kept value times beta, then sum
        logic out_load;  // load the output register
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;  // output register empty or being taken
    } t_dp_sts;

    // configuration block status
    typedef struct packed {
        logic [ERR_W-1:0] err;
        logic             gain_valid;
    } t_cfg_sts;

endpackage

// ===== rtl/core/oplp_cfg.sv =====
// configuration registers, range checks and gain-valid flag
module oplp_cfg
    import oplp_pkg::*;
#(
    parameter int GAIN_SHIFT = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [CFG_IDX_W-1:0] i_idx,
    input  logic [CFG_W-1:0]     i_wdata,
    input  logic                 i_gain_set,
    output logic [CFG_W-1:0]     o_rate,
    output logic [CFG_W-1:0]     o_cutoff,
    output t_cfg_sts             o_sts
);

    localparam logic [31:0] FreqLimit = 32'((64'd1 << (32 - GAIN_SHIFT)) / 8);

    logic [CFG_W-1:0] r_rate;
    logic [CFG_W-1:0] r_cutoff;
    logic             r_gain_valid;
    logic [ERR_W-1:0] err;

    // register writes; any write invalidates the held gain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate       <= CFG_W'(50);
            r_cutoff     <= CFG_W'(1);
            r_gain_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_gain_valid <= 1'b0;
                case (i_idx)
                    REG_SAMPLE_RATE: r_rate   <= i_wdata;
                    REG_CUTOFF_FREQ: r_cutoff <= i_wdata;
                    default: ;
                endcase
            end else if (i_gain_set) begin
                r_gain_valid <= 1'b1;
            end
        end
    end

    // range checks in priority order
    always_comb begin
        if (r_rate == '0) begin
            err = ERR_RATE_ZERO;
        end else if (32'(r_rate) >= FreqLimit) begin
            err = ERR_RATE_HIGH;
        end else if (32'(r_cutoff) >= FreqLimit) begin
            err = ERR_CUT_HIGH;
        end else if ({r_cutoff, 1'b0} >= {1'b0, r_rate}) begin
            err = ERR_NYQUIST;
        end else begin
            err = ERR_OK;
        end
    end

    assign o_rate           = r_rate;
    assign o_cutoff         = r_cutoff;
    assign o_sts.err        = err;
    assign o_sts.gain_valid = r_gain_valid;

endmodule

// ===== rtl/core/oplp_dp.sv =====
// datapath: gain divider, shared multiplier, filter state and output register
module oplp_dp
    import oplp_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32,
    parameter int GAIN_SHIFT   = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    input  logic [CFG_W-1:0] i_rate,
    input  logic [CFG_W-1:0] i_cutoff,
    input  logic [ERR_W-1:0] i_err,
    input  logic [DATA_W-1:0] i_sample,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [OUT_W-1:0] o_out_data
);

    localparam int SW = SAMPLE_WIDTH;
    // frequency bits that can pass the range checks
    localparam int FreqW  = ((29 - GAIN_SHIFT) < CFG_W) ? (29 - GAIN_SHIFT) : CFG_W;
    localparam int TauW   = GAIN_SHIFT + 3;
    localparam longint unsigned TwoPiGain =
        (TAU_Q32 + (64'd1 << (31 - GAIN_SHIFT))) >> (32 - GAIN_SHIFT);
    localparam logic [TauW-1:0] Tau = TauW'(TwoPiGain);

    logic [FreqW-1:0]        rate_t;
    logic [FreqW-1:0]        cut_t;
    logic [FreqW+TauW-1:0]   prod_ct;
    logic [32:0]             r_den;
    logic [32:0]             r_rem;
    logic [32:0]             r_q;
    logic [33:0]             rem_sh;
    logic [33:0]             rem_diff;
    logic                    rem_ge;
    logic [31:0]             alpha;
    logic [31:0]             beta;
    logic signed [SW-1:0]    r_x;
    logic signed [SW-1:0]    r_y;
    logic signed [SW-1:0]    r_term;
    logic [ERR_W-1:0]        r_err;
    logic signed [SW-1:0]    mul_op;
    logic signed [32:0]      mul_gain;
    logic signed [SW+32:0]   prod;
    logic signed [SW-1:0]    prod_hi;
    logic signed [SW-1:0]    sum;
    logic                    r_out_valid;
    logic signed [SW-1:0]    r_out_y;
    logic [ERR_W-1:0]        r_out_err;

    assign rate_t  = i_rate[FreqW-1:0];
    assign cut_t   = i_cutoff[FreqW-1:0];
    assign prod_ct = cut_t * Tau;

    // restoring division step, quotient shifts in from the right
    assign rem_sh   = {r_rem, 1'b0};
    assign rem_diff = rem_sh - {1'b0, r_den};
    assign rem_ge   = (rem_sh >= {1'b0, r_den});

    // gain as the complement of the quotient, the quotient saturated at 2^32 - 1
    assign alpha = r_q[32] ? 32'd0 : ~r_q[31:0];
    assign beta  = ~alpha;

    // shared multiplier, high word of signed sample times unsigned gain
    assign mul_op   = i_cmd.mul_b ? r_y : r_x;
    assign mul_gain = i_cmd.mul_b ? $signed({1'b0, beta}) : $signed({1'b0, alpha});
    assign prod     = mul_op * mul_gain;
    assign prod_hi  = prod[SW+31:32];
    assign sum      = r_term + prod_hi;

    // sample, denominator, divider and term registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= i_sample[SW-1:0];
            r_err <= i_err;
            r_den <= 33'(prod_ct);
        end
        if (i_cmd.den_add) begin
            r_den <= r_den + (33'(rate_t) << GAIN_SHIFT);
            r_rem <= 33'(rate_t) << (GAIN_SHIFT - 1);
        end
        if (i_cmd.div_step) begin
            if (rem_ge) begin
                r_rem <= rem_diff[32:0];
            end else begin
                r_rem <= rem_sh[32:0];
            end
            r_q <= {r_q[31:0], rem_ge};
        end
        if (i_cmd.mul_a) begin
            r_term <= prod_hi;
        end
    end

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y <= '0;
        end else if (i_cmd.mul_b) begin
            r_y <= sum;
        end
    end

    // output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload, new sum when loaded in the second multiply step
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_y   <= i_cmd.mul_b ? sum : r_y;
            r_out_err <= r_err;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = {(OUT_W - DATA_W - ERR_W)'(0), r_out_err, DATA_W'(r_out_y)};

endmodule

// ===== rtl/core/oplp_ctrl.sv =====
// controller: sequences gain division, multiply steps and output load
module oplp_ctrl
    import oplp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_cfg_sts i_cfg_sts,
    input  t_dp_sts  i_dp_sts,
    output t_dp_cmd  o_cmd,
    output logic     o_gain_set
);

    localparam int CntW = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEN,
        S_DIV,
        S_MUL_A,
        S_MUL_B,
        S_OUT
    } t_state;

    t_state          r_state;
    t_state          n_state;
    logic [CntW-1:0] r_cnt;
    logic [CntW-1:0] n_cnt;
    logic            accept;
    logic            div_last;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign div_last   = (r_cnt == CntW'(DIV_STEPS - 1));

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_gain_set = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    if (i_cfg_sts.err != ERR_OK) begin
                        n_state = S_OUT;
                    end else if (i_cfg_sts.gain_valid) begin
                        n_state = S_MUL_A;
                    end else begin
                        n_state = S_DEN;
                    end
                end
            end
            S_DEN: begin
                o_cmd.den_add = 1'b1;
                n_cnt         = '0;
                n_state       = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (div_last) begin
                    o_gain_set = 1'b1;
                    n_state    = S_MUL_A;
                end
            end
            S_MUL_A: begin
                o_cmd.mul_a = 1'b1;
                n_state     = S_MUL_B;
            end
            S_MUL_B: begin
                o_cmd.mul_b = 1'b1;
                if (i_dp_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_dp_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== rtl/core/one_pole_lowpass_with_cutoff_core.sv =====
// top level of the one-pole low-pass filter core
//
// One-pole low-pass filter on signed fixed-point samples. The gain alpha
// follows from the sample-rate and cutoff registers as the complement of
// (rate << (32+GAIN_SHIFT)) / (rate*2^GAIN_SHIFT + cutoff*2pi*2^GAIN_SHIFT),
// and each sample updates the kept value to x*alpha + y*(1-alpha). Only the
// low SAMPLE_WIDTH bits of a sample are used; results are sign-extended to
// 32 bits. One sample is handled at a time: with a held gain an accepted
// sample takes two steps on the one shared multiplier, the second adding
// the terms and loading the output register, or waiting until it is free.
// The first sample after reset or after any configuration write first
// forms the denominator and runs the bit-serial restoring divider that
// computes the gain, which is then held. When a configuration check fails,
// the kept value stays unchanged and the result carries it with the error
// code. A result waiting in the output register does not block acceptance
// of the next sample.
module one_pole_lowpass_with_cutoff_core
    import oplp_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32,
    parameter int GAIN_SHIFT   = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // sample input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [DATA_W-1:0]    s_axis_tdata,   // [31:0] sample_in
    // result output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata    // [31:0] filtered_out, [34:32] error_code
);

    t_cfg_sts         cfg_sts;
    t_dp_sts          dp_sts;
    t_dp_cmd          dp_cmd;
    logic             gain_set;
    logic [CFG_W-1:0] rate;
    logic [CFG_W-1:0] cutoff;

    // configuration registers and checks
    oplp_cfg #(
        .GAIN_SHIFT(GAIN_SHIFT)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (i_cfg_we),
        .i_idx      (i_cfg_idx),
        .i_wdata    (i_cfg_wdata),
        .i_gain_set (gain_set),
        .o_rate     (rate),
        .o_cutoff   (cutoff),
        .o_sts      (cfg_sts)
    );

    // controller
    oplp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_cfg_sts  (cfg_sts),
        .i_dp_sts   (dp_sts),
        .o_cmd      (dp_cmd),
        .o_gain_set (gain_set)
    );

    // datapath
    oplp_dp #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .GAIN_SHIFT  (GAIN_SHIFT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_rate      (rate),
        .i_cutoff    (cutoff),
        .i_err       (cfg_sts.err),
        .i_sample    (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ===== bench/one_pole_lowpass_with_cutoff_core_tb.sv =====
// self-checking testbench of the one-pole low-pass filter core
module one_pole_lowpass_with_cutoff_core_tb
    import oplp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GAIN_SHIFT = 9;
    localparam longint unsigned TWO_PI_GAIN =
        (TAU_Q32 + (64'd1 << (31 - GAIN_SHIFT))) >> (32 - GAIN_SHIFT);
    localparam longint unsigned FREQ_LIMIT = (64'd1 << (32 - GAIN_SHIFT)) / 8;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int RANDOM_SAMPLES = 950;

    // one filter output transaction
    typedef struct packed {
        logic [31:0]      value;
        logic [ERR_W-1:0] code;
    } t_lowpass_result;

    // filter model and store of expected outputs
    class lowpass_scoreboard;
        logic [CFG_W-1:0] rate_reg;
        logic [CFG_W-1:0] cutoff_reg;
        logic [31:0]      kept_value;
        t_lowpass_result  expected_q[$];
        int               fail_count;

        function new();
            rate_reg   = 24'd50;
            cutoff_reg = 24'd1;
            kept_value = '0;
            fail_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_SAMPLE_RATE) rate_reg = val;
            else if (idx == REG_CUTOFF_FREQ) cutoff_reg = val;
        endfunction

        // high word of signed sample times unsigned 0.32 gain
        function logic [31:0] fixed_mul_hi(logic [31:0] x, logic [31:0] g);
            logic [63:0] prod;
            prod = {{32{x[31]}}, x} * {32'd0, g};
            return prod[63:32];
        endfunction

        // accepted sample: update the kept value and queue the output
        function void note_sample(logic [31:0] x);
            t_lowpass_result  r;
            logic [ERR_W-1:0] err;
            longint unsigned  num, den, quot;
            logic [31:0]      alpha;

            if (rate_reg == 0) err = ERR_RATE_ZERO;
            else if (rate_reg >= FREQ_LIMIT) err = ERR_RATE_HIGH;
            else if (cutoff_reg >= FREQ_LIMIT) err = ERR_CUT_HIGH;
            else if ({cutoff_reg, 1'b0} >= {1'b0, rate_reg}) err = ERR_NYQUIST;
            else err = ERR_OK;

            if (err == ERR_OK) begin
                num  = longint'(rate_reg) << (32 + GAIN_SHIFT);
                den  = (longint'(rate_reg) << GAIN_SHIFT) + longint'(cutoff_reg) * TWO_PI_GAIN;
                quot = num / den;
                // zero cutoff gives exactly 2^32, saturated so the filter holds
                if (quot > 64'hFFFF_FFFF) quot = 64'hFFFF_FFFF;
                alpha = ~quot[31:0];
                kept_value = fixed_mul_hi(x, alpha) + fixed_mul_hi(kept_value, ~alpha);
            end
            r.value = kept_value;
            r.code  = err;
            expected_q.insert(expected_q.size(), r);
        endfunction

        // compare an accepted output transaction with the oldest expectation
        function void check_result(logic [OUT_W-1:0] tdata);
            t_lowpass_result exp_r;
            if (expected_q.size() == 0) begin
                $error("unexpected output transaction: filtered_out %h error_code %0d",
                       tdata[31:0], tdata[34:32]);
                fail_count++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (tdata[31:0] !== exp_r.value) begin
                $error("filtered_out mismatch: expected %h actual %h", exp_r.value, tdata[31:0]);
                fail_count++;
            end
            if (tdata[34:32] !== exp_r.code) begin
                $error("error_code mismatch: expected %0d actual %0d", exp_r.code, tdata[34:32]);
                fail_count++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [DATA_W-1:0]    s_axis_tdata;   // [31:0] sample_in
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;   // [31:0] filtered_out, [34:32] error_code

    lowpass_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off_req = 1'b0;
    int  samples_sent = 0;

    one_pole_lowpass_with_cutoff_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // run limit
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // output side: random stalls, or one long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // check every accepted output transaction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // offer one sample, with a random gap first, and wait for the handshake
    task automatic send_sample(input logic [31:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(x);
        samples_sent++;
    endtask

    // hold the input back until every expected output has arrived
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write both gain registers while the block is idle
    task automatic program_filter(input logic [CFG_W-1:0] rate, input logic [CFG_W-1:0] cutoff);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_SAMPLE_RATE;
        i_cfg_wdata <= rate;
        sb.write_reg(REG_SAMPLE_RATE, rate);
        @(posedge i_clk);
        i_cfg_idx   <= REG_CUTOFF_FREQ;
        i_cfg_wdata <= cutoff;
        sb.write_reg(REG_CUTOFF_FREQ, cutoff);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // stimulus
    initial begin
        int unsigned rate, cutoff;
        int          style, n_items;
        logic [31:0] level, x;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_SAMPLE_RATE;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct  = 21;
        recv_stall_pct = 55;

        // reset gain: full-scale steps, zero, small values, alternating bits
        repeat (3) send_sample(32'h7FFF_FFFF);
        repeat (3) send_sample(32'h8000_0000);
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0001);
        send_sample(32'h5555_5555);
        send_sample(32'hAAAA_AAAA);

        // each failing configuration check
        program_filter(24'd0, 24'd1);
        send_sample(32'h1234_5678);
        send_sample(32'h8000_0000);
        program_filter(24'h10_0000, 24'd1);
        send_sample(32'h7FFF_FFFF);
        program_filter(24'hFF_FFFF, 24'd1);
        send_sample(32'h7FFF_FFFF);
        program_filter(24'd1000, 24'h10_0000);
        send_sample(32'h8000_0000);
        program_filter(24'd1000, 24'hFF_FFFF);
        send_sample(32'h8000_0000);
        // nyquist boundary: twice the cutoff equals the rate
        program_filter(24'd100, 24'd50);
        send_sample(32'h7FFF_FFFF);
        // zero cutoff holds the kept value
        program_filter(24'd100, 24'd0);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        // largest legal rate and cutoff
        program_filter(24'h0F_FFFF, 24'h07_FFFF);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        // smallest legal rate
        program_filter(24'd1, 24'd0);
        send_sample(32'h4000_0000);

        // random phases, each with its own configuration
        samples_sent = 0;
        while (samples_sent < RANDOM_SAMPLES) begin
            if ($urandom_range(99) < 15) begin
                rate   = $urandom() & 32'h00FF_FFFF;
                cutoff = $urandom() & 32'h00FF_FFFF;
                if ($urandom_range(3) == 0) rate = 0;
            end else begin
                rate = $urandom() >> $urandom_range(12, 31);
                if (rate == 0) rate = 1;
                if (rate >= FREQ_LIMIT) rate = 32'(FREQ_LIMIT - 1);
                if (rate <= 1 || $urandom_range(3) == 0) cutoff = 0;
                else cutoff = $urandom_range(0, (rate - 1) / 2);
            end
            program_filter(rate[CFG_W-1:0], cutoff[CFG_W-1:0]);

            n_items = $urandom_range(20, 80);
            style   = $urandom_range(2);
            level   = $urandom();
            repeat (n_items) begin
                // idling regime follows progress through the random part
                if (samples_sent < 320) begin
                    send_idle_pct  = 21;
                    recv_stall_pct = 55;
                end else if (samples_sent < 640) begin
                    send_idle_pct  = 55;
                    recv_stall_pct = 21;
                end else begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                if (samples_sent == 300 || samples_sent == 700) hold_off_req = 1'b1;

                case (style)
                    0: x = $urandom();
                    1: begin
                        // step runs: a level held long enough to settle
                        if ($urandom_range(15) == 0) begin
                            case ($urandom_range(2))
                                0: level = 32'h7FFF_FFFF;
                                1: level = 32'h8000_0000;
                                default: level = $urandom();
                            endcase
                        end
                        x = level;
                    end
                    default: x = $urandom_range(0, 1023) - 512;
                endcase
                send_sample(x);
            end
        end

        wait_drained();
        if (sb.fail_count == 0 && sb.expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
